[rtl/gwb_pkg.sv]
// gray world white balance package: types, constants and shared arithmetic
// no dependencies; used by gwb_front, gwb_div, gwb_back and the top level
`timescale 1ns / 1ps

package gwb_pkg;

  localparam int MAX_FRAME_PIXELS = 4194304;
  localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int SUM_W = 30;
  localparam int GAIN_W = 18;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  // divider sized for the channel ratio, the wider of the two numerators
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
  localparam int PADDR_W = 5;

  typedef enum logic [1:0] {
    PASS_CHAN = 2'd0,
    PASS_LUMA = 2'd1,
    PASS_OUT  = 2'd2
  } pass_e;

  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_WB_MIN  = 3'd1,
    REG_WB_MAX  = 3'd2,
    REG_BR_MIN  = 3'd3,
    REG_BR_MAX  = 3'd4
  } reg_e;

  typedef struct packed {
    logic [7:0]        target_level;
    logic [GAIN_W-1:0] wb_gain_min;
    logic [GAIN_W-1:0] wb_gain_max;
    logic [GAIN_W-1:0] bright_gain_min;
    logic [GAIN_W-1:0] bright_gain_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0] pass_select;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } item_t;

  // (x * gain + 0.5) in q16, saturated to 8 bits
  function automatic logic [7:0] scale_sat(input logic [7:0] x, input logic [GAIN_W-1:0] g);
    logic [26:0] p;
    p = 27'(x) * 27'(g) + 27'd32768;
    return (p[26:16] > 11'd255) ? 8'd255 : p[23:16];
  endfunction

  function automatic logic [7:0] luma(input logic [7:0] b, input logic [7:0] g,
                                      input logic [7:0] r);
    logic [21:0] s;
    s = 22'(b) * 22'd1868 + 22'(g) * 22'd9617 + 22'(r) * 22'd4899 + 22'd8192;
    return s[21:14];
  endfunction

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [DIV_NUM_W-1:0] q,
                                                   input logic [GAIN_W-1:0] lo,
                                                   input logic [GAIN_W-1:0] hi);
    logic [DIV_NUM_W-1:0] v;
    v = (q < DIV_NUM_W'(lo)) ? DIV_NUM_W'(lo) : q;
    return (v > DIV_NUM_W'(hi)) ? hi : v[GAIN_W-1:0];
  endfunction

endpackage

[rtl/gwb_if.sv]
// pixel stream interfaces: valid/ready plus the item payload
// depends on nothing
`timescale 1ns / 1ps

interface gwb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] pass_select;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  logic       frame_end;
  modport source (output valid, pass_select, blue_in, green_in, red_in, frame_end,
                  input ready);
  modport sink (input valid, pass_select, blue_in, green_in, red_in, frame_end,
                output ready);
endinterface

interface gwb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       frame_end_out;
  modport source (output valid, blue_out, green_out, red_out, frame_end_out, input ready);
  modport sink (input valid, blue_out, green_out, red_out, frame_end_out, output ready);
endinterface

[rtl/gwb_front.sv]
// front end: accepts items, drops unused pass codes, queues the rest
// depends on gwb_pkg and gwb_in_if
`timescale 1ns / 1ps

module gwb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  gwb_in_if.sink         pix_i,
  output logic           q_valid_o,
  output gwb_pkg::item_t q_item_o,
  input  logic           q_pop_i
);

  gwb_pkg::item_t                 mem_q [gwb_pkg::QUEUE_DEPTH];
  logic [gwb_pkg::QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [gwb_pkg::QUEUE_AW:0]     cnt_q;
  logic                           acc, push, pop;

  assign pix_i.ready = (cnt_q != (gwb_pkg::QUEUE_AW+1)'(gwb_pkg::QUEUE_DEPTH));
  assign acc  = pix_i.valid && pix_i.ready;
  // pass code 3 carries no work
  assign push = acc && (pix_i.pass_select == gwb_pkg::PASS_CHAN ||
                        pix_i.pass_select == gwb_pkg::PASS_LUMA ||
                        pix_i.pass_select == gwb_pkg::PASS_OUT);
  assign pop  = q_pop_i && q_valid_o;

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{pass_select: pix_i.pass_select, blue: pix_i.blue_in,
                           green: pix_i.green_in, red: pix_i.red_in,
                           frame_end: pix_i.frame_end};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (gwb_pkg::QUEUE_AW+1)'(push) - (gwb_pkg::QUEUE_AW+1)'(pop);
    end
  end

endmodule

[rtl/gwb_div.sv]
// restoring divider, one quotient bit per cycle
// depends on gwb_pkg
`timescale 1ns / 1ps

module gwb_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gwb_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [gwb_pkg::DIV_DEN_W-1:0] den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [gwb_pkg::DIV_NUM_W-1:0] quo_o
);

  logic [gwb_pkg::DIV_NUM_W-1:0] num_q;
  logic [gwb_pkg::DIV_DEN_W-1:0] den_q, rem_q;
  logic [gwb_pkg::DIV_DEN_W:0]   rem_sh;
  logic [gwb_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          done_q, ge;

  assign rem_sh = {rem_q, num_q[gwb_pkg::DIV_NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quo_o  = num_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_o) begin
      num_q <= {num_q[gwb_pkg::DIV_NUM_W-2:0], ge};
      rem_q <= ge ? gwb_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_q})
                  : rem_sh[gwb_pkg::DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= gwb_pkg::DIV_CNT_W'(gwb_pkg::DIV_NUM_W);
      done_q <= 1'b0;
    end else begin
      if (busy_o) cnt_q <= cnt_q - 1'b1;
      done_q <= busy_o && (cnt_q == gwb_pkg::DIV_CNT_W'(1));
    end
  end

endmodule

[rtl/gwb_back.sv]
// back end: balancing, statistics, gain updates and the output register
// depends on gwb_pkg, gwb_out_if and gwb_div
`timescale 1ns / 1ps

module gwb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gwb_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  gwb_pkg::item_t q_item_i,
  output logic           q_pop_o,
  gwb_out_if.source      pix_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_BAL   = 7'b0000010,
    S_APPLY = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_STORE = 7'b1000000
  } state_e;

  localparam int PROD_W = 8 + gwb_pkg::CNT_W;

  state_e                        state_q, state_d;
  gwb_pkg::item_t                item_q;
  logic [7:0]                    bal_q [3];
  logic [gwb_pkg::SUM_W-1:0]     sum_q [3];
  logic [gwb_pkg::SUM_W-1:0]     luma_sum_q;
  logic [gwb_pkg::CNT_W-1:0]     cnt_q;
  logic [gwb_pkg::GAIN_W-1:0]    gain_q [3];
  logic [gwb_pkg::GAIN_W-1:0]    bgain_q;
  logic                          ben_q;
  logic [1:0]                    ch_q;
  logic [PROD_W-1:0]             prod_q;
  logic                          room, is_chan, out_free, out_load;
  logic [gwb_pkg::SUM_W-1:0]     cur_sum;
  logic [gwb_pkg::SUM_W+1:0]     total;
  logic                          div_start, div_busy, div_done;
  logic [gwb_pkg::DIV_NUM_W-1:0] div_num, div_quo;
  logic [gwb_pkg::DIV_DEN_W-1:0] div_den;
  logic [gwb_pkg::GAIN_W-1:0]    clamped;
  logic                          skip;

  assign room     = (cnt_q < gwb_pkg::CNT_W'(gwb_pkg::MAX_FRAME_PIXELS));
  assign is_chan  = (item_q.pass_select == gwb_pkg::PASS_CHAN);
  assign out_free = !pix_o.valid || pix_o.ready;
  assign out_load = (state_q == S_APPLY) && (item_q.pass_select == gwb_pkg::PASS_OUT)
                    && out_free;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    case (ch_q)
      2'd0:    cur_sum = sum_q[0];
      2'd1:    cur_sum = sum_q[1];
      default: cur_sum = sum_q[2];
    endcase
  end

  assign total = (gwb_pkg::SUM_W+2)'(sum_q[0]) + (gwb_pkg::SUM_W+2)'(sum_q[1])
               + (gwb_pkg::SUM_W+2)'(sum_q[2]);
  assign skip  = is_chan ? (cur_sum == '0) : (luma_sum_q == '0);

  // rounded quotient: (2n + d) / (2d)
  always_comb begin
    if (is_chan) begin
      div_den = gwb_pkg::DIV_DEN_W'({cur_sum, 2'b00}) + gwb_pkg::DIV_DEN_W'({cur_sum, 1'b0});
      div_num = (gwb_pkg::DIV_NUM_W'(total) << 17) + gwb_pkg::DIV_NUM_W'(cur_sum)
              + gwb_pkg::DIV_NUM_W'({cur_sum, 1'b0});
    end else begin
      div_den = gwb_pkg::DIV_DEN_W'({luma_sum_q, 1'b0});
      div_num = (gwb_pkg::DIV_NUM_W'(prod_q) << 17) + gwb_pkg::DIV_NUM_W'(luma_sum_q);
    end
  end

  assign div_start = (state_q == S_LOAD) && !skip;
  assign clamped   = is_chan
    ? gwb_pkg::clamp_gain(div_quo, cfg_i.wb_gain_min, cfg_i.wb_gain_max)
    : gwb_pkg::clamp_gain(div_quo, cfg_i.bright_gain_min, cfg_i.bright_gain_max);

  gwb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (q_valid_i) state_d = S_BAL;
      S_BAL: begin
        if (!is_chan) state_d = S_APPLY;
        else if (item_q.frame_end) state_d = S_PREP;
        else state_d = S_IDLE;
      end
      S_APPLY: begin
        if (item_q.pass_select == gwb_pkg::PASS_OUT) begin
          if (out_free) state_d = S_IDLE;
        end else begin
          state_d = item_q.frame_end ? S_PREP : S_IDLE;
        end
      end
      S_PREP:  state_d = S_LOAD;
      S_LOAD: begin
        if (!skip) state_d = S_WAIT;
        else if (!is_chan || ch_q == 2'd2) state_d = S_IDLE;
      end
      S_WAIT:  if (div_done) state_d = S_STORE;
      S_STORE: state_d = (!is_chan || ch_q == 2'd2) ? S_IDLE : S_LOAD;
      default: state_d = S_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_item_i;
    if (state_q == S_BAL) begin
      bal_q[0] <= gwb_pkg::scale_sat(item_q.blue, gain_q[0]);
      bal_q[1] <= gwb_pkg::scale_sat(item_q.green, gain_q[1]);
      bal_q[2] <= gwb_pkg::scale_sat(item_q.red, gain_q[2]);
    end
    if (state_q == S_PREP) prod_q <= PROD_W'(cfg_i.target_level) * PROD_W'(cnt_q);
    if (out_load) begin
      pix_o.blue_out      <= ben_q ? gwb_pkg::scale_sat(bal_q[0], bgain_q) : bal_q[0];
      pix_o.green_out     <= ben_q ? gwb_pkg::scale_sat(bal_q[1], bgain_q) : bal_q[1];
      pix_o.red_out       <= ben_q ? gwb_pkg::scale_sat(bal_q[2], bgain_q) : bal_q[2];
      pix_o.frame_end_out <= item_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
      luma_sum_q  <= '0;
      cnt_q       <= '0;
      gain_q[0]   <= gwb_pkg::UNITY_GAIN;
      gain_q[1]   <= gwb_pkg::UNITY_GAIN;
      gain_q[2]   <= gwb_pkg::UNITY_GAIN;
      bgain_q     <= gwb_pkg::UNITY_GAIN;
      ben_q       <= 1'b0;
      ch_q        <= '0;
      pix_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) pix_o.valid <= 1'b1;
      else if (pix_o.ready) pix_o.valid <= 1'b0;

      if (state_q == S_BAL && is_chan && room) begin
        sum_q[0] <= sum_q[0] + gwb_pkg::SUM_W'(item_q.blue);
        sum_q[1] <= sum_q[1] + gwb_pkg::SUM_W'(item_q.green);
        sum_q[2] <= sum_q[2] + gwb_pkg::SUM_W'(item_q.red);
        cnt_q    <= cnt_q + 1'b1;
      end
      if (state_q == S_APPLY && item_q.pass_select == gwb_pkg::PASS_LUMA && room) begin
        luma_sum_q <= luma_sum_q + gwb_pkg::SUM_W'(gwb_pkg::luma(bal_q[0], bal_q[1], bal_q[2]));
        cnt_q      <= cnt_q + 1'b1;
      end
      if (state_q == S_PREP) ch_q <= '0;

      if ((state_q == S_LOAD && skip) || state_q == S_STORE) begin
        if (is_chan) begin
          gain_q[ch_q] <= (state_q == S_STORE) ? clamped : gwb_pkg::UNITY_GAIN;
          if (ch_q == 2'd2) begin
            sum_q[0] <= '0;
            sum_q[1] <= '0;
            sum_q[2] <= '0;
            cnt_q    <= '0;
          end else begin
            ch_q <= ch_q + 1'b1;
          end
        end else begin
          bgain_q    <= (state_q == S_STORE) ? clamped : gwb_pkg::UNITY_GAIN;
          ben_q      <= (state_q == S_STORE);
          luma_sum_q <= '0;
          cnt_q      <= '0;
        end
      end
    end
  end

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= gwb_pkg::CNT_W'(gwb_pkg::MAX_FRAME_PIXELS)) else $error("pixel count overflow");
  a_luma_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STORE && !is_chan) |=> ben_q && luma_sum_q == '0)
    else $error("brightness gain not committed");
  a_out_only_pass2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pix_o.valid) |-> $past(item_q.pass_select == gwb_pkg::PASS_OUT))
    else $error("result from a statistics pass");

endmodule

[rtl/gray_world_white_balance_brightness_unit.sv]
// gray world white balance with brightness correction, top level
// path: a pass 2 item goes through the queue, item register, balance register and output register
// sequencing: the back end takes one item at a time (pop, balance, and apply for pass 1
// or pass 2 items) and pops no new item until done with the last; the end of a statistics
// pass adds the three channel divisions, or the brightness division, in the shared divider
// reset: asynchronous active low; control and config registers return to defaults, gains to unity
`timescale 1ns / 1ps

module gray_world_white_balance_brightness_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gwb_in_if.sink                      pix_i,
  gwb_out_if.source                   pix_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gwb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  gwb_pkg::cfg_t  cfg_q;
  logic           q_valid, q_pop;
  gwb_pkg::item_t q_item;
  logic           wr_en;
  logic [2:0]     reg_idx;

  // apb: always ready, write lands in the access phase
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_level    <= 8'd128;
      cfg_q.wb_gain_min     <= gwb_pkg::GAIN_W'(32768);
      cfg_q.wb_gain_max     <= gwb_pkg::GAIN_W'(131072);
      cfg_q.bright_gain_min <= gwb_pkg::GAIN_W'(32768);
      cfg_q.bright_gain_max <= gwb_pkg::GAIN_W'(98304);
    end else if (wr_en) begin
      // addresses beyond the register list are dropped
      case (reg_idx)
        gwb_pkg::REG_TARGET: cfg_q.target_level    <= pwdata[7:0];
        gwb_pkg::REG_WB_MIN: cfg_q.wb_gain_min     <= pwdata[gwb_pkg::GAIN_W-1:0];
        gwb_pkg::REG_WB_MAX: cfg_q.wb_gain_max     <= pwdata[gwb_pkg::GAIN_W-1:0];
        gwb_pkg::REG_BR_MIN: cfg_q.bright_gain_min <= pwdata[gwb_pkg::GAIN_W-1:0];
        gwb_pkg::REG_BR_MAX: cfg_q.bright_gain_max <= pwdata[gwb_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      gwb_pkg::REG_TARGET: prdata = 32'(cfg_q.target_level);
      gwb_pkg::REG_WB_MIN: prdata = 32'(cfg_q.wb_gain_min);
      gwb_pkg::REG_WB_MAX: prdata = 32'(cfg_q.wb_gain_max);
      gwb_pkg::REG_BR_MIN: prdata = 32'(cfg_q.bright_gain_min);
      gwb_pkg::REG_BR_MAX: prdata = 32'(cfg_q.bright_gain_max);
      default:             prdata = '0;
    endcase
  end

  // front end: input handshake and item queue
  gwb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back end: per-pass datapath, gain updates, output register
  gwb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .pix_o     (pix_o)
  );

endmodule
